FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent check forms for the sampler
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define PCCS_ASSERT_IMP(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("same-cycle check failed");

// next-cycle implication
`define PCCS_ASSERT_NXT(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("next-cycle check failed");

`endif

FILE: hw/rtl/pccs_pkg.sv
// ----------------------------------------------------------------------------
// pccs_pkg
// widths, constants, datapath commands and status for the cdf sampler
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pccs_pkg;

    localparam int MAX_ENTRIES = 1024;
    localparam int CNT_W       = 11;
    localparam int IDX_W       = 10;
    localparam int W_W         = 32;
    localparam int U_W         = 24;
    localparam int CDF_W       = 25;
    localparam int TOT_W       = 42;
    localparam int WN_W        = 43;
    localparam int AB_W        = 36;
    localparam int DIV_SH_W    = 32;
    localparam int DIV_CNT_W   = 6;

    localparam logic [CDF_W-1:0]     CDF_ONE    = 25'h1000000;
    localparam logic [W_W-1:0]       DENS_UNIT  = 32'h00010000;
    localparam logic [W_W-1:0]       DENS_SAT   = 32'hFFFFFFFF;
    localparam logic [DIV_CNT_W-1:0] STEPS_FRAC = 6'd24;
    localparam logic [DIV_CNT_W-1:0] STEPS_DENS = 6'd32;

    localparam int OP_W = 5;
    localparam logic [OP_W-1:0] OP_NONE  = 5'd0;
    localparam logic [OP_W-1:0] OP_LOAD  = 5'd1;
    localparam logic [OP_W-1:0] OP_BINIT = 5'd2;
    localparam logic [OP_W-1:0] OP_BRD   = 5'd3;
    localparam logic [OP_W-1:0] OP_BACC  = 5'd4;
    localparam logic [OP_W-1:0] OP_BWR   = 5'd5;
    localparam logic [OP_W-1:0] OP_SINIT = 5'd6;
    localparam logic [OP_W-1:0] OP_SCHK  = 5'd7;
    localparam logic [OP_W-1:0] OP_SCMP  = 5'd8;
    localparam logic [OP_W-1:0] OP_RD0   = 5'd9;
    localparam logic [OP_W-1:0] OP_RD1   = 5'd10;
    localparam logic [OP_W-1:0] OP_MUL1  = 5'd11;
    localparam logic [OP_W-1:0] OP_MUL2  = 5'd12;
    localparam logic [OP_W-1:0] OP_XDIV  = 5'd13;
    localparam logic [OP_W-1:0] OP_XCAP  = 5'd14;
    localparam logic [OP_W-1:0] OP_DDIV  = 5'd15;
    localparam logic [OP_W-1:0] OP_DCAP  = 5'd16;
    localparam logic [OP_W-1:0] OP_OUT   = 5'd17;
    localparam logic [OP_W-1:0] OP_ERR   = 5'd18;

    typedef struct packed {
        logic            accept;
        logic [OP_W-1:0] op;
    } cmd_t;

    typedef struct packed {
        logic ready;
        logic last;
        logic div_busy;
        logic srch_more;
        logic build_last;
    } status_t;

endpackage

FILE: hw/rtl/pccs_div.sv
// ----------------------------------------------------------------------------
// pccs_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pccs_div (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [pccs_pkg::TOT_W-1:0]      rem_init,
    input  logic [pccs_pkg::DIV_SH_W-1:0]   shin_init,
    input  logic [pccs_pkg::DIV_CNT_W-1:0]  steps,
    input  logic [pccs_pkg::TOT_W-1:0]      divisor,
    output logic                            busy,
    output logic [pccs_pkg::DIV_SH_W-1:0]   quot
);
    import pccs_pkg::*;

    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [TOT_W-1:0]     rem_reg, rem_next;
    logic [DIV_SH_W-1:0]  sh_reg, sh_next;
    logic [DIV_SH_W-1:0]  q_reg, q_next;
    logic [TOT_W-1:0]     dvs_reg, dvs_next;
    logic [TOT_W:0]       trial;
    logic                 fits;

    assign trial = {rem_reg, sh_reg[DIV_SH_W-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_comb
    begin
        cnt_next = cnt_reg;
        rem_next = rem_reg;
        sh_next  = sh_reg;
        q_next   = q_reg;
        dvs_next = dvs_reg;
        if (start)
        begin
            cnt_next = steps;
            rem_next = rem_init;
            sh_next  = shin_init;
            q_next   = '0;
            dvs_next = divisor;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 1'b1;
            sh_next  = {sh_reg[DIV_SH_W-2:0], 1'b0};
            q_next   = {q_reg[DIV_SH_W-2:0], fits};
            rem_next = fits ? TOT_W'(trial - {1'b0, dvs_reg}) : TOT_W'(trial);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        sh_reg  <= sh_next;
        q_reg   <= q_next;
        dvs_reg <= dvs_next;
    end

    assign busy = cnt_reg != '0;
    assign quot = q_reg;

endmodule

FILE: hw/rtl/pccs_datapath.sv
// ----------------------------------------------------------------------------
// pccs_datapath
// weight and cdf memories, table build, search, multiply and divide
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pccs_datapath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  pccs_pkg::cmd_t              cmd,
    output pccs_pkg::status_t           status,
    input  logic [pccs_pkg::W_W-1:0]    weight,
    input  logic                        last_weight,
    input  logic [pccs_pkg::U_W-1:0]    uniform_u,
    output logic                        done,
    output logic [pccs_pkg::U_W-1:0]    position_x,
    output logic [pccs_pkg::W_W-1:0]    density,
    output logic [pccs_pkg::IDX_W-1:0]  interval_index,
    output logic                        sample_error
);
    import pccs_pkg::*;

    logic [W_W-1:0]   weight_mem [0:MAX_ENTRIES-1];
    logic [CDF_W-1:0] cdf_mem    [0:MAX_ENTRIES];

    // control state
    logic [CNT_W-1:0] count_reg, count_next;
    logic [TOT_W-1:0] total_reg, total_next;
    logic             ready_reg, ready_next;
    logic             valid_reg, valid_next;
    logic             err_reg, err_next;

    // payload
    logic [W_W-1:0]   w_in_reg;
    logic [U_W-1:0]   u_in_reg;
    logic             last_reg;
    logic [CNT_W-1:0] bi_reg, bi_next;
    logic [TOT_W-1:0] run_reg, run_next;
    logic             full_reg, full_next;
    logic [IDX_W-1:0] lo_reg, lo_next;
    logic [CNT_W-1:0] hi_reg, hi_next;
    logic [CDF_W-1:0] c0_reg, c0_next;
    logic [CDF_W-1:0] d_reg, d_next;
    logic [CDF_W-1:0] uoff_reg, uoff_next;
    logic [WN_W-1:0]  wn_reg, wn_next;
    logic [AB_W-1:0]  a_reg, a_next;
    logic [AB_W-1:0]  b_reg, b_next;
    logic [U_W-1:0]   x_reg, x_next;
    logic [W_W-1:0]   dens_reg, dens_next;
    logic             ddiv_reg, ddiv_next;
    logic [U_W-1:0]   px_reg, px_next;
    logic [W_W-1:0]   dout_reg, dout_next;
    logic [IDX_W-1:0] idx_reg, idx_next;

    // memory ports
    logic             w_we;
    logic [IDX_W-1:0] w_waddr, w_raddr;
    logic [W_W-1:0]   w_rd_reg;
    logic             c_we;
    logic [CNT_W-1:0] c_waddr, c_raddr;
    logic [CDF_W-1:0] c_wdata, c_rd_reg;

    // divider
    logic                 div_start, div_busy;
    logic [TOT_W-1:0]     div_rem, div_dvs;
    logic [DIV_SH_W-1:0]  div_sh, div_q;
    logic [DIV_CNT_W-1:0] div_steps;

    logic [CNT_W-1:0] mid;
    logic [TOT_W-1:0] build_a, build_b, run_sum;
    logic             dens_sat;

    assign mid      = CNT_W'({1'b0, lo_reg}) + CNT_W'((hi_reg - CNT_W'(lo_reg)) >> 1);
    assign run_sum  = run_reg + TOT_W'(w_rd_reg);
    assign build_a  = (total_reg == '0) ? TOT_W'(bi_reg) : run_sum;
    assign build_b  = (total_reg == '0) ? TOT_W'(count_reg) : total_reg;
    assign dens_sat = {15'b0, wn_reg} >= {total_reg, 16'b0};

    always_comb
    begin
        count_next = count_reg;
        total_next = total_reg;
        ready_next = ready_reg;
        valid_next = 1'b0;
        err_next   = err_reg;
        bi_next    = bi_reg;
        run_next   = run_reg;
        full_next  = full_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        c0_next    = c0_reg;
        d_next     = d_reg;
        uoff_next  = uoff_reg;
        wn_next    = wn_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        x_next     = x_reg;
        dens_next  = dens_reg;
        ddiv_next  = ddiv_reg;
        px_next    = px_reg;
        dout_next  = dout_reg;
        idx_next   = idx_reg;
        w_we       = 1'b0;
        w_waddr    = count_reg[IDX_W-1:0];
        w_raddr    = lo_reg;
        c_we       = 1'b0;
        c_waddr    = bi_reg;
        c_wdata    = '0;
        c_raddr    = mid;
        div_start  = 1'b0;
        div_rem    = '0;
        div_sh     = '0;
        div_steps  = STEPS_FRAC;
        div_dvs    = build_b;

        case (cmd.op)
            OP_LOAD:
            begin
                if (ready_reg)
                begin
                    ready_next = 1'b0;
                    w_we       = 1'b1;
                    w_waddr    = '0;
                    count_next = CNT_W'(1);
                    total_next = TOT_W'(w_in_reg);
                end
                else if (count_reg < CNT_W'(MAX_ENTRIES))
                begin
                    w_we       = 1'b1;
                    count_next = count_reg + 1'b1;
                    total_next = total_reg + TOT_W'(w_in_reg);
                end
            end
            OP_BINIT:
            begin
                c_we    = 1'b1;
                c_waddr = '0;
                bi_next = CNT_W'(1);
                run_next = '0;
            end
            OP_BRD:
            begin
                w_raddr = IDX_W'(bi_reg - 1'b1);
            end
            OP_BACC:
            begin
                run_next  = run_sum;
                full_next = build_a >= build_b;
                div_start = 1'b1;
                div_rem   = build_a;
                div_dvs   = build_b;
            end
            OP_BWR:
            begin
                c_we    = 1'b1;
                c_wdata = full_reg ? CDF_ONE : div_q[CDF_W-1:0];
                if (bi_reg == count_reg)
                    ready_next = 1'b1;
                else
                    bi_next = bi_reg + 1'b1;
            end
            OP_SINIT:
            begin
                lo_next = '0;
                hi_next = count_reg;
            end
            OP_SCHK:
            begin
                c_raddr = mid;
            end
            OP_SCMP:
            begin
                if (c_rd_reg <= {1'b0, u_in_reg})
                    lo_next = mid[IDX_W-1:0];
                else
                    hi_next = mid;
            end
            OP_RD0:
            begin
                c_raddr = CNT_W'(lo_reg);
            end
            OP_RD1:
            begin
                c0_next = c_rd_reg;
                c_raddr = CNT_W'(lo_reg) + 1'b1;
                w_raddr = lo_reg;
            end
            OP_MUL1:
            begin
                d_next    = c_rd_reg - c0_reg;
                uoff_next = {1'b0, u_in_reg} - c0_reg;
                wn_next   = w_rd_reg * count_reg;
            end
            OP_MUL2:
            begin
                a_next = AB_W'(lo_reg) * AB_W'(d_reg) + AB_W'(uoff_reg);
                b_next = AB_W'(d_reg) * AB_W'(count_reg);
            end
            OP_XDIV:
            begin
                div_start = 1'b1;
                div_rem   = TOT_W'(a_reg);
                div_dvs   = TOT_W'(b_reg);
            end
            OP_XCAP:
            begin
                x_next = div_q[U_W-1:0];
            end
            OP_DDIV:
            begin
                ddiv_next = 1'b0;
                if (total_reg == '0)
                    dens_next = DENS_UNIT;
                else if (dens_sat)
                    dens_next = DENS_SAT;
                else
                begin
                    ddiv_next = 1'b1;
                    div_start = 1'b1;
                    div_rem   = TOT_W'(wn_reg[WN_W-1:16]);
                    div_sh    = {wn_reg[15:0], 16'b0};
                    div_steps = STEPS_DENS;
                    div_dvs   = total_reg;
                end
            end
            OP_DCAP:
            begin
                if (ddiv_reg)
                    dens_next = div_q;
            end
            OP_OUT:
            begin
                valid_next = 1'b1;
                err_next   = 1'b0;
                px_next    = x_reg;
                dout_next  = dens_reg;
                idx_next   = lo_reg;
            end
            OP_ERR:
            begin
                valid_next = 1'b1;
                err_next   = 1'b1;
                px_next    = '0;
                dout_next  = '0;
                idx_next   = '0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            total_reg <= '0;
            ready_reg <= 1'b0;
            valid_reg <= 1'b0;
            err_reg   <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            total_reg <= total_next;
            ready_reg <= ready_next;
            valid_reg <= valid_next;
            err_reg   <= err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            w_in_reg <= weight;
            u_in_reg <= uniform_u;
            last_reg <= last_weight;
        end
        bi_reg   <= bi_next;
        run_reg  <= run_next;
        full_reg <= full_next;
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        c0_reg   <= c0_next;
        d_reg    <= d_next;
        uoff_reg <= uoff_next;
        wn_reg   <= wn_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        x_reg    <= x_next;
        dens_reg <= dens_next;
        ddiv_reg <= ddiv_next;
        px_reg   <= px_next;
        dout_reg <= dout_next;
        idx_reg  <= idx_next;
    end

    always_ff @(posedge clk)
    begin
        if (w_we)
            weight_mem[w_waddr] <= w_in_reg;
        w_rd_reg <= weight_mem[w_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (c_we)
            cdf_mem[c_waddr] <= c_wdata;
        c_rd_reg <= cdf_mem[c_raddr];
    end

    pccs_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .rem_init  (div_rem),
        .shin_init (div_sh),
        .steps     (div_steps),
        .divisor   (div_dvs),
        .busy      (div_busy),
        .quot      (div_q)
    );

    assign status.ready      = ready_reg;
    assign status.last       = last_reg;
    assign status.div_busy   = div_busy;
    assign status.srch_more  = (hi_reg - CNT_W'(lo_reg)) > CNT_W'(1);
    assign status.build_last = bi_reg == count_reg;

    assign done           = valid_reg;
    assign position_x     = px_reg;
    assign density        = dout_reg;
    assign interval_index = idx_reg;
    assign sample_error   = err_reg;

endmodule

FILE: hw/rtl/pccs_ctrl.sv
// ----------------------------------------------------------------------------
// pccs_ctrl
// sequencer for load, table build and sample
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pccs_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                func,
    output logic                busy,
    output pccs_pkg::cmd_t      cmd,
    input  pccs_pkg::status_t   status
);
    import pccs_pkg::*;

    localparam int ST_W = 5;
    localparam logic [ST_W-1:0] ST_IDLE   = 5'd0;
    localparam logic [ST_W-1:0] ST_LOAD   = 5'd1;
    localparam logic [ST_W-1:0] ST_BINIT  = 5'd2;
    localparam logic [ST_W-1:0] ST_BRD    = 5'd3;
    localparam logic [ST_W-1:0] ST_BACC   = 5'd4;
    localparam logic [ST_W-1:0] ST_BWAIT  = 5'd5;
    localparam logic [ST_W-1:0] ST_BWR    = 5'd6;
    localparam logic [ST_W-1:0] ST_SINIT  = 5'd7;
    localparam logic [ST_W-1:0] ST_SCHK   = 5'd8;
    localparam logic [ST_W-1:0] ST_SCMP   = 5'd9;
    localparam logic [ST_W-1:0] ST_RD1    = 5'd10;
    localparam logic [ST_W-1:0] ST_MUL1   = 5'd11;
    localparam logic [ST_W-1:0] ST_MUL2   = 5'd12;
    localparam logic [ST_W-1:0] ST_XSTART = 5'd13;
    localparam logic [ST_W-1:0] ST_XWAIT  = 5'd14;
    localparam logic [ST_W-1:0] ST_DSTART = 5'd15;
    localparam logic [ST_W-1:0] ST_DWAIT  = 5'd16;
    localparam logic [ST_W-1:0] ST_OUT    = 5'd17;
    localparam logic [ST_W-1:0] ST_ERR    = 5'd18;

    logic [ST_W-1:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd.accept = 1'b0;
        cmd.op     = OP_NONE;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.accept = 1'b1;
                    if (!func)
                        state_next = ST_LOAD;
                    else if (status.ready)
                        state_next = ST_SINIT;
                    else
                        state_next = ST_ERR;
                end
            end
            ST_LOAD:
            begin
                cmd.op     = OP_LOAD;
                state_next = status.last ? ST_BINIT : ST_IDLE;
            end
            ST_BINIT:
            begin
                cmd.op     = OP_BINIT;
                state_next = ST_BRD;
            end
            ST_BRD:
            begin
                cmd.op     = OP_BRD;
                state_next = ST_BACC;
            end
            ST_BACC:
            begin
                cmd.op     = OP_BACC;
                state_next = ST_BWAIT;
            end
            ST_BWAIT:
            begin
                if (!status.div_busy)
                    state_next = ST_BWR;
            end
            ST_BWR:
            begin
                cmd.op     = OP_BWR;
                state_next = status.build_last ? ST_IDLE : ST_BRD;
            end
            ST_SINIT:
            begin
                cmd.op     = OP_SINIT;
                state_next = ST_SCHK;
            end
            ST_SCHK:
            begin
                if (status.srch_more)
                begin
                    cmd.op     = OP_SCHK;
                    state_next = ST_SCMP;
                end
                else
                begin
                    cmd.op     = OP_RD0;
                    state_next = ST_RD1;
                end
            end
            ST_SCMP:
            begin
                cmd.op     = OP_SCMP;
                state_next = ST_SCHK;
            end
            ST_RD1:
            begin
                cmd.op     = OP_RD1;
                state_next = ST_MUL1;
            end
            ST_MUL1:
            begin
                cmd.op     = OP_MUL1;
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                cmd.op     = OP_MUL2;
                state_next = ST_XSTART;
            end
            ST_XSTART:
            begin
                cmd.op     = OP_XDIV;
                state_next = ST_XWAIT;
            end
            ST_XWAIT:
            begin
                if (!status.div_busy)
                begin
                    cmd.op     = OP_XCAP;
                    state_next = ST_DSTART;
                end
            end
            ST_DSTART:
            begin
                cmd.op     = OP_DDIV;
                state_next = ST_DWAIT;
            end
            ST_DWAIT:
            begin
                if (!status.div_busy)
                begin
                    cmd.op     = OP_DCAP;
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                cmd.op     = OP_OUT;
                state_next = ST_IDLE;
            end
            ST_ERR:
            begin
                cmd.op     = OP_ERR;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = state_reg != ST_IDLE;

endmodule

FILE: hw/rtl/piecewise_constant_cdf_sampler.sv
// ----------------------------------------------------------------------------
// piecewise_constant_cdf_sampler
// inverse-cdf sampler over a piecewise-constant weight table
// ----------------------------------------------------------------------------
// usage:
//   a beat is taken when start is high and busy is low. func low loads one
//   weight; last_weight high on a load then builds the normalized cdf table.
//   func high draws one sample for uniform_u.
//   the build after the last weight is bounded by the serial divider, one
//   24-bit quotient per table entry.
//   a sample runs a binary search with one cdf memory read per step, then
//   a 24-bit and a 32-bit quotient division on the shared divider (the
//   second is skipped when all weights are zero or the density saturates).
//   done pulses for one cycle with the result.
//   a sample when no table is ready (none built yet, or a new load begun)
//   gives a result with sample_error set.
//   reset clears the table state; stores are not cleared and need no sweep.
//   the receiver cannot stall; results must be taken in their done cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module piecewise_constant_cdf_sampler (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        func,
    input  logic [pccs_pkg::W_W-1:0]    weight,
    input  logic                        last_weight,
    input  logic [pccs_pkg::U_W-1:0]    uniform_u,
    output logic                        done,
    output logic [pccs_pkg::U_W-1:0]    position_x,
    output logic [pccs_pkg::W_W-1:0]    density,
    output logic [pccs_pkg::IDX_W-1:0]  interval_index,
    output logic                        sample_error
);
    import pccs_pkg::*;

    cmd_t    cmd;
    status_t status;

    pccs_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .func   (func),
        .busy   (busy),
        .cmd    (cmd),
        .status (status)
    );

    pccs_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .weight         (weight),
        .last_weight    (last_weight),
        .uniform_u      (uniform_u),
        .done           (done),
        .position_x     (position_x),
        .density        (density),
        .interval_index (interval_index),
        .sample_error   (sample_error)
    );

    `PCCS_ASSERT_IMP(a_done_idle, clk, rst_n, done, !busy)
    `PCCS_ASSERT_IMP(a_err_zero, clk, rst_n, done && sample_error, ~|{position_x, density})
    `PCCS_ASSERT_IMP(a_err_idx, clk, rst_n, done && sample_error, interval_index == '0)
    `PCCS_ASSERT_NXT(a_accept_busy, clk, rst_n, start && !busy, busy && !done)
    `PCCS_ASSERT_NXT(a_load_no_result, clk, rst_n, start && !busy && !func, !done)

endmodule
